// File: rtl/core/stkufp_pkg.sv
// ----------------------------------------------------------------------------
// stkufp_pkg
// Shared types and constants for the thumbstick frame parser.
// ----------------------------------------------------------------------------
package stkufp_pkg;

  typedef logic [7:0]        byte_t;
  typedef logic signed [15:0] axis_t;
  typedef logic [6:0]        dzone_t;
  typedef logic [2:0]        cnt_t;

  localparam int unsigned FRAME_LEN = 6;
  localparam int unsigned KEEP_MAX  = 5;

  localparam byte_t  MARK_START   = 8'hff;
  localparam byte_t  MARK_END     = 8'hfe;
  localparam dzone_t DZONE_RESET  = 7'd10;
  localparam axis_t  AXIS_MIN     = 16'sh8000;
  localparam axis_t  AXIS_MAX     = 16'sh7fff;
  localparam cnt_t   CNT_FULL     = 3'd5;

  // Frame detector status toward the top level
  typedef struct packed {
    logic  hit;
    byte_t x_raw;
    byte_t y_raw;
  } frame_t;

endpackage

// File: rtl/core/stkufp_if.sv
// ----------------------------------------------------------------------------
// stkufp_if
// Valid/ready channels: received byte in, axis pair out.
// ----------------------------------------------------------------------------
interface stkufp_byte_if
  import stkufp_pkg::*;
  ();
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface stkufp_axis_if
  import stkufp_pkg::*;
  ();
  logic  valid;
  logic  ready;
  axis_t axis_x;
  axis_t axis_y;

  modport source (output valid, output axis_x, output axis_y, input ready);
  modport sink   (input valid, input axis_x, input axis_y, output ready);
endinterface

// File: rtl/core/stkufp_axis_scale.sv
// ----------------------------------------------------------------------------
// stkufp_axis_scale
// Centers one axis byte on 128, applies dead zone, saturation and scaling.
// ----------------------------------------------------------------------------
module stkufp_axis_scale
  import stkufp_pkg::*;
(
  input  byte_t  raw,
  input  dzone_t dead_zone,
  output axis_t  axis
);

  logic signed [7:0] d;
  logic [7:0]        mag;

  // Offset from center: flipping the top bit subtracts 128
  assign d   = $signed({~raw[7], raw[6:0]});
  assign mag = d[7] ? 8'(-d) : 8'(d);

  always_comb begin
    priority if (mag < {1'b0, dead_zone}) begin
      axis = '0;
    end else if (d <= -8'sd64) begin
      axis = AXIS_MIN;
    end else if (d >= 8'sd64) begin
      axis = AXIS_MAX;
    end else begin
      // d fits in 7 signed bits here, so d*512 is a plain shift
      axis = {d[6:0], 9'b0};
    end
  end

endmodule

// File: rtl/core/stkufp_frame_window.sv
// ----------------------------------------------------------------------------
// stkufp_frame_window
// Holds up to five pending bytes and finds six-byte frames in one pass.
// ----------------------------------------------------------------------------
module stkufp_frame_window
  import stkufp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  byte_t  new_byte,
  output frame_t frame
);

  byte_t pend_r   [KEEP_MAX];
  byte_t pend_nxt [KEEP_MAX];
  cnt_t  cnt_r, cnt_nxt;

  byte_t win [FRAME_LEN];
  logic  full;
  cnt_t  s;
  cnt_t  sh;
  logic  hit;

  // Six-byte window when the buffer is full
  always_comb begin
    for (int i = 0; i < int'(KEEP_MAX); i++) win[i] = pend_r[i];
    win[FRAME_LEN-1] = new_byte;
  end

  assign full = (cnt_r == CNT_FULL);

  // First start marker in the window; 6 when none
  always_comb begin
    s = 3'(FRAME_LEN);
    for (int i = int'(FRAME_LEN) - 1; i >= 0; i--) begin
      if (win[i] == MARK_START) s = 3'(i);
    end
  end

  assign hit = full && (s == '0) && (win[FRAME_LEN-1] == MARK_END);
  // Aligned but bad end marker drops one byte
  assign sh  = (s == '0) ? 3'd1 : s;

  // Next buffer contents and fill count
  always_comb begin
    for (int i = 0; i < int'(KEEP_MAX); i++) pend_nxt[i] = pend_r[i];
    cnt_nxt = cnt_r;
    if (step) begin
      if (!full) begin
        for (int i = 0; i < int'(KEEP_MAX); i++) begin
          if (cnt_r == 3'(i)) pend_nxt[i] = new_byte;
        end
        cnt_nxt = cnt_r + 3'd1;
      end else if (hit) begin
        cnt_nxt = '0;
      end else begin
        for (int k = 1; k < int'(FRAME_LEN); k++) begin
          if (sh == 3'(k)) begin
            for (int i = 0; i + k < int'(FRAME_LEN); i++) pend_nxt[i] = win[i+k];
          end
        end
        cnt_nxt = 3'(FRAME_LEN) - sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(KEEP_MAX); i++) pend_r[i] <= pend_nxt[i];
  end

  assign frame.hit   = step && hit;
  assign frame.x_raw = win[3];
  assign frame.y_raw = win[4];

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL) else $error("pending count out of range");
  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    frame.hit |=> cnt_r == '0) else $error("buffer not emptied after frame");
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cnt_r)) else $error("count moved without a word");

endmodule

// File: rtl/core/stick_uart_frame_parser.sv
// ----------------------------------------------------------------------------
// stick_uart_frame_parser
// Thumbstick serial frame parser: bytes in, scaled X/Y axis pairs out.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, and its result in the
//   result register. Throughput: one byte per cycle while the result register is
//   free or being drained; window search and axis scaling sit between the two.
// Reset: clears the pending count and both valid flags; dead_zone resets
//   to 10. Pending byte storage is not reset.
module stick_uart_frame_parser
  import stkufp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  stkufp_byte_if.sink       in_word,
  stkufp_axis_if.source     out_word,
  input  logic              cfg_we,
  input  dzone_t            cfg_wdata
);

  logic   s1_valid_r;
  byte_t  s1_byte_r;
  logic   out_valid_r;
  axis_t  out_x_r, out_y_r;
  dzone_t dzone_r;
  logic   adv;
  logic   step;
  frame_t frame;
  axis_t  ax_x, ax_y;

  // Stage advances when the result register is free or being drained
  assign adv           = !out_valid_r || out_word.ready;
  assign step          = s1_valid_r && adv;
  assign in_word.ready = !s1_valid_r || adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dzone_r <= DZONE_RESET;
    end else if (cfg_we) begin
      dzone_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready && in_word.valid) begin
      s1_byte_r <= in_word.data_byte;
    end
  end

  stkufp_frame_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .new_byte (s1_byte_r),
    .frame    (frame)
  );

  stkufp_axis_scale u_scale_x (
    .raw       (frame.x_raw),
    .dead_zone (dzone_r),
    .axis      (ax_x)
  );

  stkufp_axis_scale u_scale_y (
    .raw       (frame.y_raw),
    .dead_zone (dzone_r),
    .axis      (ax_y)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= frame.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && frame.hit) begin
      out_x_r <= ax_x;
      out_y_r <= ax_y;
    end
  end

  assign out_word.valid  = out_valid_r;
  assign out_word.axis_x = out_x_r;
  assign out_word.axis_y = out_y_r;

  // Checks
  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r)) else $error("result without a word");
  a_stall_blocks_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word.ready) |-> !step) else $error("step during stall");
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost a word");

endmodule

// File: verif/stick_uart_frame_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_uart_frame_parser_test
// Self-checking bench for the thumbstick frame parser. A short table of
// bytes covers the axis extremes, a dead-zone edge, a stray leading byte and
// a frame with a bad end marker. Random phases follow, each under its own
// dead zone. Most of their traffic is well-formed frames, and the rest is
// broken frames and noise. Every accepted byte runs through a local frame
// tracker, and each axis pair that leaves the block is checked against the
// oldest predicted pair.
// ----------------------------------------------------------------------------
module stick_uart_frame_parser_test;
  import stkufp_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 105;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned PRINT_CAP       = 50;
  localparam int unsigned DIR_ROWS        = 25;

  // How a table row is checked: by the tracker, by the pair typed in, or not at all
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_PAIR} exp_kind_t;

  typedef struct {
    byte_t     data;
    exp_kind_t kind;
    axis_t     x;
    axis_t     y;
  } stim_row_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
  } axis_pair_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  dzone_t cfg_wdata;

  stkufp_byte_if byte_ch ();
  stkufp_axis_if axis_ch ();

  stick_uart_frame_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (byte_ch),
    .out_word (axis_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Frame tracker state
  byte_t       held_bytes [KEEP_MAX];
  int unsigned held_cnt;
  dzone_t      dz_model;

  axis_pair_t  axis_expect_q [$];
  int unsigned mismatch_cnt;
  int unsigned idle_cycles;
  bit          in_live;
  bit          in_steady;
  bit          out_steady;

  // Directed bytes: stray byte, extremes, dead-zone edge, bad end marker, resync
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00, EXP_NONE,  16'sd0,   16'sd0},
    '{8'hff, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h12, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h34, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h00, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'hff, EXP_NONE,  16'sd0,   16'sd0},
    '{8'hfe, EXP_PAIR,  AXIS_MIN, AXIS_MAX},
    '{8'hff, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'haa, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h55, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h89, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h76, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'hfe, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'hff, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h01, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h02, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h03, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h04, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h05, EXP_NONE,  16'sd0,   16'sd0},
    '{8'hff, EXP_NONE,  16'sd0,   16'sd0},
    '{8'h7f, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h80, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'hc0, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'h40, EXP_MODEL, 16'sd0,   16'sd0},
    '{8'hfe, EXP_PAIR,  AXIS_MAX, AXIS_MIN}
  };

  // Center on 128, dead zone first, then saturate or scale
  function automatic axis_t scale_axis(input byte_t raw);
    int d;
    int mag;
    d   = int'(raw) - 128;
    mag = (d < 0) ? -d : d;
    if (mag < int'(dz_model)) return '0;
    if (d <= -64) return AXIS_MIN;
    if (d >= 64) return AXIS_MAX;
    return axis_t'(d * 512);
  endfunction

  // Push one byte into the pending window; returns 1 when a frame completes
  function automatic bit parse_byte(input byte_t b, output axis_t px, output axis_t py);
    byte_t       win [FRAME_LEN];
    int unsigned n;
    int unsigned s;
    bit          hit;
    hit = 1'b0;
    px  = '0;
    py  = '0;
    for (int i = 0; i < held_cnt; i++) win[i] = held_bytes[i];
    win[held_cnt] = b;
    n = held_cnt + 1;
    if (n == FRAME_LEN) begin
      // drop leading bytes that cannot start a frame
      s = 0;
      while (s < n && win[s] != MARK_START) s++;
      for (int i = 0; i + s < n; i++) win[i] = win[i + s];
      n = n - s;
      if (n == FRAME_LEN) begin
        if (win[5] == MARK_END) begin
          px  = scale_axis(win[3]);
          py  = scale_axis(win[4]);
          hit = 1'b1;
          n   = 0;
        end else begin
          // bad end marker: only the start byte goes
          for (int i = 0; i < n - 1; i++) win[i] = win[i + 1];
          n = n - 1;
        end
      end
    end
    for (int i = 0; i < n; i++) held_bytes[i] = win[i];
    held_cnt = n;
    return hit;
  endfunction

  // Axis byte biased toward the dead-zone edge and the saturation point
  function automatic byte_t pick_axis_byte();
    int c;
    int sgn;
    int jit;
    sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
    jit = int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 4))
      0: c = 128 + sgn * (int'(dz_model) + jit);
      1: c = 128 + sgn * (64 + jit);
      2: c = 128 + int'($urandom_range(0, 24)) - 12;
      default: c = int'($urandom_range(0, 255));
    endcase
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return byte_t'(c);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Drive one word, after a random gap unless steady, and record its predicted pair
  task automatic send_word(input byte_t b, input exp_kind_t kind = EXP_MODEL,
                           input axis_t ex = '0, input axis_t ey = '0);
    int unsigned gap;
    axis_t       px;
    axis_t       py;
    bit          hit;
    gap = in_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      if (in_live) begin
        byte_ch.valid <= 1'b0;
        in_live = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    in_live = 1'b1;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    hit = parse_byte(b, px, py);
    case (kind)
      EXP_MODEL: if (hit) axis_expect_q.push_back(axis_pair_t'{px, py});
      EXP_PAIR:  axis_expect_q.push_back(axis_pair_t'{ex, ey});
      default: ;
    endcase
  endtask

  // Hold the sender until every predicted pair is out
  task automatic wait_results();
    if (in_live) begin
      byte_ch.valid <= 1'b0;
      in_live = 1'b0;
    end
    while (axis_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_dead_zone(input dzone_t v);
    wait_results();
    // a byte that gave no pair may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dz_model = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall per word unless steady, then check against the oldest pair
  initial begin
    int unsigned stall;
    axis_pair_t  want;
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        axis_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      axis_ch.ready <= 1'b1;
      do @(posedge clk); while (axis_ch.valid !== 1'b1);
      if (axis_expect_q.size() == 0) begin
        report_mismatch($sformatf("axis pair x=%0d y=%0d with none pending",
                                  axis_ch.axis_x, axis_ch.axis_y));
      end else begin
        want = axis_expect_q.pop_front();
        if (axis_ch.axis_x !== want.x)
          report_mismatch($sformatf("axis_x got %0d want %0d", axis_ch.axis_x, want.x));
        if (axis_ch.axis_y !== want.y)
          report_mismatch($sformatf("axis_y got %0d want %0d", axis_ch.axis_y, want.y));
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (axis_ch.valid && axis_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Main sequence
  initial begin
    dzone_t      dz_plan [PHASES];
    byte_t       seq [$];
    byte_t       bad_tail;
    int unsigned sent;
    int unsigned seq_idx;
    int unsigned drain_seq;
    int unsigned r;
    int unsigned cut;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    idle_cycles  = 0;
    mismatch_cnt = 0;
    in_live      = 1'b0;
    in_steady    = 1'b0;
    out_steady   = 1'b0;
    held_cnt     = 0;
    dz_model     = DZONE_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset dead zone
    foreach (dir_tab[i]) send_word(dir_tab[i].data, dir_tab[i].kind, dir_tab[i].x, dir_tab[i].y);

    // Dead zones: none, saturation point, full width, smallest, random, reset value
    dz_plan[0] = 7'd0;
    dz_plan[1] = 7'd64;
    dz_plan[2] = 7'd127;
    dz_plan[3] = 7'd1;
    dz_plan[4] = dzone_t'($urandom_range(0, 64));
    dz_plan[5] = DZONE_RESET;

    for (int ph = 0; ph < PHASES; ph++) begin
      load_dead_zone(dz_plan[ph]);
      in_steady  = (ph == 2);
      out_steady = (ph == 2) || (ph == 4);
      sent      = 0;
      seq_idx   = 0;
      drain_seq = $urandom_range(2, 10);
      while (sent < ITEMS_PER_PHASE) begin
        if (seq_idx == drain_seq || $urandom_range(0, 49) == 0) wait_results();
        seq.delete();
        r = $urandom_range(0, 99);
        if (r < 85) begin
          // frame body; good, bad end marker, or cut short
          seq.push_back(MARK_START);
          repeat (2)
            seq.push_back(($urandom_range(0, 7) == 0) ? MARK_START
                                                      : byte_t'($urandom_range(0, 255)));
          seq.push_back(pick_axis_byte());
          seq.push_back(pick_axis_byte());
          bad_tail = byte_t'($urandom_range(0, 255));
          if (bad_tail == MARK_END) bad_tail = ~bad_tail;
          seq.push_back((r < 65 || r >= 72) ? MARK_END : bad_tail);
          if (r >= 72) begin
            cut = $urandom_range(1, 5);
            while (seq.size() > cut) void'(seq.pop_back());
          end
        end else begin
          // line noise
          repeat ($urandom_range(1, 3)) seq.push_back(byte_t'($urandom_range(0, 255)));
        end
        foreach (seq[i]) send_word(seq[i]);
        sent += seq.size();
        seq_idx++;
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/stkufp_pkg.sv
rtl/core/stkufp_if.sv
rtl/core/stkufp_axis_scale.sv
rtl/core/stkufp_frame_window.sv
rtl/core/stick_uart_frame_parser.sv
verif/stick_uart_frame_parser_test.sv
